// ----- hw/rtl/rled_pkg.sv -----
// ----------------------------------------------------------------------------
// rled_pkg
// Shared types and codes for the run-length LED frame decoder.
// ----------------------------------------------------------------------------
package rled_pkg;

	typedef enum logic [1:0] {
		CMD_RUN    = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_COPY,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear_en;
		logic run_en;
		logic copy_en;
		logic read_en;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_go;
		logic run_last;
		logic ptr_last;
	} dp_stat_t;

endpackage

// ----- hw/rtl/rled_ctrl.sv -----
// ----------------------------------------------------------------------------
// rled_ctrl
// Sequencer for clearing, runs, commits and reads.
// ----------------------------------------------------------------------------
module rled_ctrl
	import rled_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cmd_code_t  cmd_code,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  ctl,
	output logic       busy,
	output logic       done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_en = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					case (cmd_code)
						CMD_RUN:    state_d = stat.run_go ? ST_RUN : ST_DONE;
						CMD_COMMIT: state_d = ST_COPY;
						CMD_READ:   state_d = ST_READ;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RUN: begin
				ctl.run_en = 1'b1;
				if (stat.run_last) begin
					state_d = ST_DONE;
				end
			end
			ST_COPY: begin
				ctl.copy_en = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_READ: begin
				ctl.read_en = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/rled_dp.sv -----
// ----------------------------------------------------------------------------
// rled_dp
// Staging and display memories, fill position, flags and sweep pointer.
// ----------------------------------------------------------------------------
module rled_dp
	import rled_pkg::*;
#(
	parameter int PIXEL_COUNT = 90
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  ctl,
	output dp_stat_t   stat,
	input  cmd_code_t  cmd_code,
	input  logic [7:0] run_length,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       last_record,
	input  logic [6:0] read_index,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [6:0] fill_position,
	output logic       overflow
);

	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int PW = $clog2(PIXEL_COUNT + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(PIXEL_COUNT - 1);
	localparam logic [PW-1:0] WP_END   = PW'(PIXEL_COUNT);

	logic [23:0]   stg_mem [PIXEL_COUNT];
	logic [23:0]   disp_mem [PIXEL_COUNT];

	logic [PW-1:0] wp_q;
	logic          ovf_q;
	logic          stop_q;
	logic [7:0]    cnt_q;
	logic [23:0]   color_q;
	logic [AW-1:0] ptr_q;
	logic [6:0]    idx_q;
	logic          rd_sel_q;
	logic          cp_v_s1;
	logic [AW-1:0] cp_addr_s1;
	logic [23:0]   stg_rd_s1;
	logic [23:0]   disp_rd_q;

	logic          wp_end;
	logic          stg_we;
	logic [AW-1:0] stg_wa;
	logic [23:0]   stg_wd;
	logic          disp_we;
	logic [AW-1:0] disp_wa;
	logic [23:0]   disp_wd;

	assign wp_end        = (wp_q == WP_END);
	assign stat.run_go   = !stop_q && (run_length != 8'd0);
	assign stat.run_last = (cnt_q == 8'd1) || wp_end;
	assign stat.ptr_last = (ptr_q == PTR_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			ovf_q    <= 1'b0;
			stop_q   <= 1'b0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			rd_sel_q <= 1'b0;
			cp_v_s1  <= 1'b0;
		end else begin
			cp_v_s1 <= ctl.copy_en;
			if (ctl.load) begin
				ptr_q    <= '0;
				rd_sel_q <= (cmd_code == CMD_READ) &&
				            (32'(read_index) < 32'(PIXEL_COUNT));
				case (cmd_code)
					CMD_RUN: begin
						cnt_q <= run_length;
						if (stop_q) begin
							if (last_record) begin
								stop_q <= 1'b0;
							end
						end else if (run_length == 8'd0) begin
							stop_q <= !last_record;
						end
					end
					CMD_COMMIT: begin
						wp_q   <= '0;
						ovf_q  <= 1'b0;
						stop_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.clear_en || ctl.copy_en) begin
				ptr_q <= ptr_q + AW'(1);
			end
			// write while room is left, flag overflow once the end is hit
			if (ctl.run_en) begin
				if (wp_end) begin
					ovf_q <= 1'b1;
				end else begin
					wp_q  <= wp_q + PW'(1);
					cnt_q <= cnt_q - 8'd1;
				end
			end
		end
	end

	// payload holds, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			color_q <= {red_in, green_in, blue_in};
			idx_q   <= read_index;
		end
		cp_addr_s1 <= ptr_q;
	end

	assign stg_we  = ctl.clear_en || (ctl.run_en && !wp_end);
	assign stg_wa  = ctl.clear_en ? ptr_q : wp_q[AW-1:0];
	assign stg_wd  = ctl.clear_en ? 24'd0 : color_q;
	assign disp_we = ctl.clear_en || cp_v_s1;
	assign disp_wa = ctl.clear_en ? ptr_q : cp_addr_s1;
	assign disp_wd = ctl.clear_en ? 24'd0 : stg_rd_s1;

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[stg_wa] <= stg_wd;
		end
		if (ctl.copy_en) begin
			stg_rd_s1 <= stg_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (disp_we) begin
			disp_mem[disp_wa] <= disp_wd;
		end
		if (ctl.read_en && rd_sel_q) begin
			disp_rd_q <= disp_mem[AW'(idx_q)];
		end
	end

	assign red_out       = rd_sel_q ? disp_rd_q[23:16] : 8'd0;
	assign green_out     = rd_sel_q ? disp_rd_q[15:8]  : 8'd0;
	assign blue_out      = rd_sel_q ? disp_rd_q[7:0]   : 8'd0;
	assign fill_position = 7'(wp_q);
	assign overflow      = ovf_q;

endmodule

// ----- hw/rtl/rle_led_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_led_frame_decoder
// Run-length RGB decoder into a staging buffer, committed to a display buffer.
// ----------------------------------------------------------------------------
//
//  channel   handshake           fields
//  -------   -----------------   ---------------------------------------------
//  command   start / busy        cmd, run_length, red_in, green_in, blue_in,
//                                last_record, read_index
//  result    done (one cycle)    red_out, green_out, blue_out, fill_position,
//                                overflow
//
//  An item is taken when start is high and busy is low; its result shows on
//  the result ports for the single cycle in which done is high, after which
//  busy drops. Work per item after it is taken:
//    run record:   one staging pixel per cycle through the staging write port
//    commit:       one entry per cycle staging -> display
//    read:         through the registered display read
//    stopped or zero-length record, unused code: straight to done
//  After reset a clearing pass zeroes both memories with busy held high.
//  The receiver cannot stall: done is never held.
//
module rle_led_frame_decoder
	import rled_pkg::*;
#(
	parameter int PIXEL_COUNT = 90
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] run_length,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       last_record,
	input  logic [6:0] read_index,
	output logic       done,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [6:0] fill_position,
	output logic       overflow
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;
	cmd_code_t cmd_code;

	assign cmd_code = cmd_code_t'(cmd);

	// sequence the work of each item
	rled_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd_code (cmd_code),
		.stat     (stat),
		.ctl      (ctl),
		.busy     (busy),
		.done     (done)
	);

	// hold buffers, fill position and flags
	rled_dp #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd_code      (cmd_code),
		.run_length    (run_length),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.last_record   (last_record),
		.read_index    (read_index),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.fill_position (fill_position),
		.overflow      (overflow)
	);

`ifndef SYNTH
	// an accepted item keeps the block busy until its result is out
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// exactly one result cycle per item
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done && !busy)
		else $error("result strobe repeated or block not released");

	// no result while idle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe while idle");

	// red output is zero unless the item was a read
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd != CMD_READ |=> !(red_out != 8'd0 && done))
		else $error("color output on a non-read item");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the run-length LED frame decoder. A queue of pending
// items feeds a falling-edge driver. A rising-edge monitor predicts each
// accepted item against a behavioral copy of the staging and display buffers,
// then checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
	import rled_pkg::*;
();

	localparam int PIXELS     = 90;
	localparam int RAND_ITEMS = 850;
	localparam int STALL_MAX  = 2000;	// idle cycles before the run is declared hung

	typedef struct {
		cmd_code_t  cmd;
		logic [7:0] run_length;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_record;
		logic [6:0] read_index;
	} frame_cmd_t;

	typedef struct {
		frame_cmd_t item;
		int         idle_pct;	// chance per cycle that the sender holds off
		bit         drain;	// hold this item until every result is back
	} pending_cmd_t;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [6:0] fill_position;
		logic       overflow;
	} pixel_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	frame_cmd_t drv = '{cmd: CMD_RUN, default: '0};

	logic       busy;
	logic       done;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [6:0] fill_position;
	logic       overflow;

	// Predicted decoder state
	logic [23:0] staging_px [PIXELS];
	logic [23:0] display_px [PIXELS];
	int          fill_ptr;
	logic        overflow_seen;
	logic        report_halted;

	pending_cmd_t  cmd_q [$];
	pixel_result_t decoded_q [$];

	int queued_count   = 0;
	int accepted_count = 0;
	int mismatch_count = 0;
	int stall_cycles   = 0;
	int last_phase     = -1;
	logic taken = 1'b0;	// item on the ports was accepted at the last rising edge

	always #10 clk = ~clk;

	rle_led_frame_decoder #(
		.PIXEL_COUNT(PIXELS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (drv.cmd),
		.run_length   (drv.run_length),
		.red_in       (drv.red),
		.green_in     (drv.green),
		.blue_in      (drv.blue),
		.last_record  (drv.last_record),
		.read_index   (drv.read_index),
		.done         (done),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.fill_position(fill_position),
		.overflow     (overflow)
	);

	// Apply one item to the predicted buffers and return the result it must produce.
	function automatic pixel_result_t decode_item(input frame_cmd_t it);
		pixel_result_t res;
		logic [23:0]   colour;
		int            k;
		res    = '{default: '0};
		colour = {it.red, it.green, it.blue};
		case (it.cmd)
			CMD_RUN: begin
				if (report_halted) begin
					// skip the rest of a stopped report; its last record re-arms decoding
					if (it.last_record)
						report_halted = 1'b0;
				end else if (it.run_length == 8'd0) begin
					report_halted = !it.last_record;
				end else begin
					for (k = 0; k < it.run_length; k++) begin
						if (fill_ptr < PIXELS) begin
							staging_px[fill_ptr] = colour;
							fill_ptr++;
						end else begin
							overflow_seen = 1'b1;	// drop pixels past the end
						end
					end
				end
			end
			CMD_COMMIT: begin
				display_px    = staging_px;
				fill_ptr      = 0;
				overflow_seen = 1'b0;
				report_halted = 1'b0;
			end
			CMD_READ: begin
				if (it.read_index < PIXELS)
					{res.red, res.green, res.blue} = display_px[it.read_index];
			end
			default: ;
		endcase
		res.fill_position = fill_ptr[6:0];
		res.overflow      = overflow_seen;
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Append an item; the sender's idle rate follows the phase of the run.
	task automatic queue_item(input cmd_code_t c, input logic [7:0] len,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic lst, input logic [6:0] idx, input bit drain);
		pending_cmd_t pc;
		int           phase;
		phase = queued_count * 4 / (RAND_ITEMS + 25);
		if (phase > 3)
			phase = 3;
		pc.item     = '{cmd: c, run_length: len, red: r, green: g, blue: b,
				last_record: lst, read_index: idx};
		// phases: no idling, sender idle 61 %, no idling, sender idle 9 %
		case (phase)
			1: pc.idle_pct = 61;
			3: pc.idle_pct = 9;
			default: pc.idle_pct = 0;
		endcase
		// let the block go quiet at each phase change and now and then at random
		pc.drain   = drain || (phase != last_phase) || ($urandom_range(99) < 3);
		last_phase = phase;
		cmd_q.push_back(pc);
		queued_count++;
	endtask

	// Driver: present a new item once the previous one is taken, or on a free cycle.
	always @(negedge clk) begin : drive_proc
		pending_cmd_t nxt;
		if (arst_n && (!start || taken)) begin
			if (cmd_q.size() != 0 && !(cmd_q[0].drain && decoded_q.size() != 0)
					&& $urandom_range(99) >= cmd_q[0].idle_pct) begin
				nxt = cmd_q.pop_front();
				drv   <= nxt.item;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check the done strobe, then record any item accepted at this edge.
	always @(posedge clk) begin : watch_proc
		pixel_result_t want;
		if (arst_n) begin
			if (done) begin
				if (decoded_q.size() == 0) begin
					flag_mismatch("unexpected done", {31'd0, done}, 32'd0);
				end else begin
					want = decoded_q.pop_front();
					if (red_out !== want.red)
						flag_mismatch("red_out", 32'(red_out), 32'(want.red));
					if (green_out !== want.green)
						flag_mismatch("green_out", 32'(green_out), 32'(want.green));
					if (blue_out !== want.blue)
						flag_mismatch("blue_out", 32'(blue_out), 32'(want.blue));
					if (fill_position !== want.fill_position)
						flag_mismatch("fill_position", 32'(fill_position),
								32'(want.fill_position));
					if (overflow !== want.overflow)
						flag_mismatch("overflow", 32'(overflow), 32'(want.overflow));
				end
			end
			if (start && !busy) begin
				decoded_q.push_back(decode_item(drv));
				accepted_count++;
			end
			taken        <= start && !busy;
			stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
		end
	end

	// Watchdog: end a hung run
	initial begin
		while (stall_cycles < STALL_MAX)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int         n;
		int         i;
		int         sel;
		int         total;
		logic [7:0] len;
		logic       lst;
		bit         broken;

		foreach (staging_px[k]) begin
			staging_px[k] = '0;
			display_px[k] = '0;
		end
		fill_ptr      = 0;
		overflow_seen = 1'b0;
		report_halted = 1'b0;

		// --- directed part ---
		// display is all zero after reset, and out-of-range reads give zero
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_READ, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 7'd127, 1'b0);
		// unused code with every field high
		queue_item(CMD_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 7'h7f, 1'b0);
		// zero length marked last: nothing stops
		queue_item(CMD_RUN, 8'd0, 8'h11, 8'h22, 8'h33, 1'b1, 7'd0, 1'b0);
		// zero length mid-report stops; following records are skipped up to the last
		queue_item(CMD_RUN, 8'd0, 8'h11, 8'h22, 8'h33, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd5, 8'hff, 8'h00, 8'hff, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd3, 8'h0f, 8'hf0, 8'h0f, 1'b1, 7'd0, 1'b0);
		// fill to exactly the end, then one past it
		queue_item(CMD_RUN, 8'd89, 8'h12, 8'h34, 8'h56, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd1, 8'hff, 8'hff, 8'hff, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd1, 8'h80, 8'h01, 8'h7f, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd255, 8'h00, 8'h00, 8'h00, 1'b1, 7'd0, 1'b0);
		// commit clears overflow and fill position
		queue_item(CMD_COMMIT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b1);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd88, 1'b0);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd89, 1'b0);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd90, 1'b0);
		// one long run overflows on its own
		queue_item(CMD_RUN, 8'd255, 8'haa, 8'h55, 8'haa, 1'b0, 7'd0, 1'b0);
		// a commit also clears a stopped report
		queue_item(CMD_RUN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_COMMIT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_RUN, 8'd1, 8'h01, 8'h80, 8'h7f, 1'b1, 7'd0, 1'b0);
		queue_item(CMD_COMMIT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd0, 1'b0);
		queue_item(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 7'd1, 1'b1);

		// --- random part: mostly well-formed reports followed by commit and reads ---
		total = queued_count + RAND_ITEMS;
		while (queued_count < total) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				n      = $urandom_range(1, 12);
				broken = ($urandom_range(9) == 0);
				for (i = 0; i < n; i++) begin
					sel = $urandom_range(99);
					if (sel < 70)
						len = 8'($urandom_range(1, 12));
					else if (sel < 78)
						len = 8'($urandom_range(13, 40));
					else if (sel < 90)
						len = 8'($urandom_range(255));
					else
						len = 8'd0;
					lst = (i == n - 1) && !broken;
					if (i != n - 1 && $urandom_range(49) == 0)
						lst = 1'b1;
					queue_item(CMD_RUN, len, 8'($urandom_range(255)),
							8'($urandom_range(255)), 8'($urandom_range(255)), lst,
							7'($urandom_range(127)), 1'b0);
				end
				if ($urandom_range(9) < 7)
					queue_item(CMD_COMMIT, 8'($urandom_range(255)), 8'($urandom_range(255)),
							8'($urandom_range(255)), 8'($urandom_range(255)),
							1'($urandom_range(1)), 7'($urandom_range(127)), 1'b0);
				n = $urandom_range(0, 6);
				for (i = 0; i < n; i++)
					queue_item(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
							8'($urandom_range(255)), 8'($urandom_range(255)),
							1'($urandom_range(1)),
							($urandom_range(9) == 0) ? 7'($urandom_range(90, 127))
									: 7'($urandom_range(89)), 1'b0);
			end else if (sel < 75) begin
				queue_item(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 7'($urandom_range(127)), 1'b0);
			end else if (sel < 85) begin
				queue_item(CMD_COMMIT, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 7'($urandom_range(127)), 1'b0);
			end else if (sel < 92) begin
				queue_item(CMD_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 7'($urandom_range(127)), 1'b0);
			end else begin
				// noise: a lone record with random content
				queue_item(CMD_RUN, 8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 7'($urandom_range(127)), 1'b0);
			end
		end

		// hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait until every item is taken and every result has come back
		while (accepted_count < queued_count || decoded_q.size() != 0)
			@(negedge clk);
		// leave room for a stray done, longer than a commit
		repeat (120) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
